### sv/assert_macros.svh
// Assertion macros shared by the mapper RTL.
// Every user provides i_clk and the active-low synchronous reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define APHCM_ASSERT(NAME, PROP, MSG) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) PROP) \
        else $error(MSG);

// Check a property on every clock edge, reset included.
`define APHCM_ASSERT_ALL(NAME, PROP, MSG) \
    NAME: assert property (@(posedge i_clk) PROP) \
        else $error(MSG);

`endif

### sv/aphcm_pkg.sv
// Shared types, constants and the hue-to-color table for the peak color mapper.
// No dependencies; every mapper module imports it.
package aphcm_pkg;

    // Field and port widths
    localparam int PEAK_W      = 16;
    localparam int HUE_W       = 9;
    localparam int LVL_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int CHAN_W      = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;
    localparam int FRAC_BITS   = 12;

    // Pipeline stage positions
    localparam int NUM_STAGES = 7;
    localparam int ST_GAIN_A  = 0;
    localparam int ST_GAIN_B  = 1;
    localparam int ST_SCALE   = 2;
    localparam int ST_ROUND   = 3;
    localparam int ST_LEVEL   = 4;
    localparam int ST_MIX     = 5;
    localparam int ST_OUT     = 6;

    // Hue geometry
    localparam int HUE_FULL  = 360;
    localparam int HUE_STEPS = 90;
    localparam int REM_W     = 7;

    // Color channel positions
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Divide by 510 through a reciprocal: exact for dividends below 2^24
    localparam int MIX_Y_W     = 24;
    localparam int MIX_RECIP_W = 25;
    localparam int MIX_SHIFT   = 33;
    localparam logic [MIX_RECIP_W-1:0] MIX_RECIP =
        MIX_RECIP_W'(((64'd1 << MIX_SHIFT) + 64'd509) / 64'd510);

    // Trig constants used only while building the table
    localparam longint unsigned RAD_PER_DEG_Q30 = 64'd18740330;
    localparam longint          TRIG_ONE        = 64'sd16384;
    localparam longint          CH_DIV          = 64'sd16384000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PEAK_MIN      = 3'd0,
        CFG_PEAK_MAX      = 3'd1,
        CFG_MATERIAL_GAIN = 3'd2,
        CFG_GLOBAL_GAIN   = 3'd3,
        CFG_COLOR_MODE    = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_HUE_A = 3'd1,
        MODE_HUE_B = 3'd2,
        MODE_RED   = 3'd3,
        MODE_GREEN = 3'd4,
        MODE_BLUE  = 3'd5
    } t_color_mode;

    typedef struct packed {
        logic signed [LVL_W-1:0]  peak_min;
        logic signed [LVL_W-1:0]  peak_max;
        logic        [GAIN_W-1:0] material_gain;
        logic        [GAIN_W-1:0] global_gain;
        t_color_mode              color_mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        peak_min:      '0,
        peak_max:      LVL_W'(1 << FRAC_BITS),
        material_gain: GAIN_W'(256),
        global_gain:   GAIN_W'(256),
        color_mode:    MODE_NONE
    };

    // Per-stage load enables and valid bits
    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef t_chan [2:0] t_rgb;
    typedef t_rgb [3:0] t_hue_row;
    typedef t_hue_row [0:HUE_STEPS-1] t_hue_tbl;

    // Q14 sine of whole degrees 0..90, Q30 Taylor series to x^9
    function automatic int sin_q14(input int unsigned d);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        x   = longint'(d) * RAD_PER_DEG_Q30;
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        t   = ((t * x2) >> 30) / 6;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 20;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 42;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 72;
        sum = sum + longint'(t);
        if (sum < 0) begin
            sum = 0;
        end
        return int'(($unsigned(sum) + 64'd32768) >> 16);
    endfunction

    // One rotated channel, truncated and saturated to 0..255
    function automatic t_chan chan_val(input int a, input int b, input int c,
                                       input int cs, input int sn);
        longint num;
        longint q;
        num = 255 * (longint'(a) * TRIG_ONE + longint'(b) * cs + longint'(c) * sn);
        if (num <= 0) begin
            return '0;
        end
        q = num / CH_DIV;
        return (q > 255) ? t_chan'(255) : t_chan'(q);
    endfunction

    // Rotated red, green and blue for every remainder and quadrant
    function automatic t_hue_tbl build_hue_tbl();
        t_hue_tbl tbl;
        int       sa;
        int       sb;
        int       sn;
        int       cs;
        for (int r = 0; r < HUE_STEPS; r++) begin
            sa = sin_q14(r);
            sb = sin_q14(HUE_STEPS - r);
            for (int q = 0; q < 4; q++) begin
                unique case (q)
                    0:       begin sn = sa;  cs = sb;  end
                    1:       begin sn = sb;  cs = -sa; end
                    2:       begin sn = -sa; cs = -sb; end
                    default: begin sn = -sb; cs = sa;  end
                endcase
                tbl[r][q][CH_RED]   = chan_val(299, 701, 168, cs, sn);
                tbl[r][q][CH_GREEN] = chan_val(299, -299, -328, cs, sn);
                tbl[r][q][CH_BLUE]  = chan_val(299, -300, 1250, cs, sn);
            end
        end
        return tbl;
    endfunction

    localparam t_hue_tbl HUE_TBL = build_hue_tbl();

endpackage

### sv/aphcm_ctrl.sv
// Pipeline flow control for the mapper: per-stage valid bits and load enables.
// Depends on aphcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aphcm_ctrl
    import aphcm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_rdy;
    logic [NUM_STAGES-1:0] w_adv;

    // Ripple ready backward so bubbles collapse; advance each stage that has room
    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_adv[0] = w_rdy[0] && i_in_valid;
        n_vld[0] = w_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            w_adv[k] = w_rdy[k] && r_vld[k-1];
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    // Hold the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_ctl.adv   = w_adv;
    assign o_ctl.vld   = r_vld;

    `APHCM_ASSERT_ALL(a_rst_clears, !i_rst_n |=> (r_vld == '0), "pipe not empty after reset")
    `APHCM_ASSERT(a_item_count, $past(i_rst_n) |-> ($countones(r_vld) == $countones($past(r_vld)) + $past(i_in_valid && w_rdy[0]) - $past(r_vld[ST_OUT] && i_out_ready)), "beat lost or duplicated in pipe")
    `APHCM_ASSERT(a_out_from_pipe, $rose(r_vld[ST_OUT]) |-> $past(r_vld[ST_MIX]), "output valid without a feeding stage")

endmodule

### sv/aphcm_hue.sv
// Hue path: reduce the angle, look up the rotated color, apply the color mode.
// Depends on aphcm_pkg (color mode codes and the hue table).
module aphcm_hue
    import aphcm_pkg::*;
(
    input  logic             i_clk,
    input  t_pipe_ctl        i_ctl,
    input  t_cfg             i_cfg,
    input  logic [HUE_W-1:0] i_hue_degrees,
    output t_rgb             o_rgb
);

    logic [HUE_W-1:0] w_h;
    logic [1:0]       w_quad;
    logic [HUE_W-1:0] w_rem;
    logic [1:0]       r_quad;
    logic [REM_W-1:0] r_rem;
    t_hue_row         w_row;
    t_rgb             w_rgb;
    t_rgb             r_rgb;
    t_rgb             r_rgb_d [ST_SCALE:ST_LEVEL];

    // Fold the angle into one turn, then split into quadrant and remainder
    always_comb begin
        w_h = (i_hue_degrees >= HUE_W'(HUE_FULL)) ? i_hue_degrees - HUE_W'(HUE_FULL)
                                                  : i_hue_degrees;
        priority if (w_h >= HUE_W'(3 * HUE_STEPS)) begin
            w_quad = 2'd3;
            w_rem  = w_h - HUE_W'(3 * HUE_STEPS);
        end else if (w_h >= HUE_W'(2 * HUE_STEPS)) begin
            w_quad = 2'd2;
            w_rem  = w_h - HUE_W'(2 * HUE_STEPS);
        end else if (w_h >= HUE_W'(HUE_STEPS)) begin
            w_quad = 2'd1;
            w_rem  = w_h - HUE_W'(HUE_STEPS);
        end else begin
            w_quad = 2'd0;
            w_rem  = w_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_GAIN_A]) begin
            r_quad <= w_quad;
            r_rem  <= w_rem[REM_W-1:0];
        end
    end

    // Look up the rotated color and pick the channels the mode asks for
    always_comb begin
        w_row = HUE_TBL[r_rem];
        w_rgb = '0;
        unique case (i_cfg.color_mode)
            MODE_HUE_A, MODE_HUE_B: w_rgb = w_row[r_quad];
            MODE_RED:               w_rgb[CH_RED]   = t_chan'(255);
            MODE_GREEN:             w_rgb[CH_GREEN] = t_chan'(255);
            MODE_BLUE:              w_rgb[CH_BLUE]  = t_chan'(255);
            default:                w_rgb = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_GAIN_B]) begin
            r_rgb <= w_rgb;
        end
    end

    // Carry the color alongside the level stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_SCALE]) begin
            r_rgb_d[ST_SCALE] <= r_rgb;
        end
        for (int k = ST_SCALE + 1; k <= ST_LEVEL; k++) begin
            if (i_ctl.adv[k]) begin
                r_rgb_d[k] <= r_rgb_d[k-1];
            end
        end
    end

    assign o_rgb = r_rgb_d[ST_LEVEL];

endmodule

### sv/aphcm_level.sv
// Level path: apply both gains, scale into the range, round and clamp.
// Depends on aphcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aphcm_level
    import aphcm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  t_cfg                    i_cfg,
    input  logic [PEAK_W-1:0]       i_peak_level,
    output logic signed [LVL_W-1:0] o_level
);

    logic        [2*GAIN_W-1:0]           r_p1;
    logic        [PEAK_W+2*GAIN_W-1:0]    w_gprod;
    logic        [2*GAIN_W-1:0]           r_g;
    logic signed [LVL_W:0]                w_range;
    logic signed [2*GAIN_W+LVL_W+1:0]     r_prod;
    logic        [2*GAIN_W+LVL_W+1:0]     w_mag;
    logic        [2*GAIN_W+LVL_W+1:0]     w_rnd;
    logic        [2*GAIN_W+1:0]           w_term_mag;
    logic signed [2*GAIN_W+2:0]           r_term;
    logic signed [2*GAIN_W+3:0]           w_val;
    logic signed [2*GAIN_W+3:0]           w_min_x;
    logic signed [2*GAIN_W+3:0]           w_max_x;
    logic signed [LVL_W-1:0]              r_level;
    logic signed [LVL_W-1:0]              w_lo_bound;
    logic signed [LVL_W-1:0]              w_hi_bound;

    // Peak times global gain
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_GAIN_A]) begin
            r_p1 <= i_peak_level * i_cfg.global_gain;
        end
    end

    // Times material gain, drop sixteen fraction bits
    assign w_gprod = r_p1 * i_cfg.material_gain;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_GAIN_B]) begin
            r_g <= w_gprod[PEAK_W +: 2*GAIN_W];
        end
    end

    // Scale the gain by the signed output range
    assign w_range = {i_cfg.peak_max[LVL_W-1], i_cfg.peak_max}
                   - {i_cfg.peak_min[LVL_W-1], i_cfg.peak_min};

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_SCALE]) begin
            r_prod <= $signed({1'b0, r_g}) * w_range;
        end
    end

    // Round the magnitude half away from zero, restore the sign
    assign w_mag      = r_prod[$high(r_prod)] ? $unsigned(-r_prod) : $unsigned(r_prod);
    assign w_rnd      = w_mag + ($bits(w_mag))'(32768);
    assign w_term_mag = w_rnd[$high(w_rnd):16];

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_ROUND]) begin
            r_term <= r_prod[$high(r_prod)] ? -$signed({1'b0, w_term_mag})
                                            : $signed({1'b0, w_term_mag});
        end
    end

    // Offset by the lower bound, clamp against the upper bound first
    always_comb begin
        w_min_x = {{(2*GAIN_W+4-LVL_W){i_cfg.peak_min[LVL_W-1]}}, i_cfg.peak_min};
        w_max_x = {{(2*GAIN_W+4-LVL_W){i_cfg.peak_max[LVL_W-1]}}, i_cfg.peak_max};
        w_val   = {r_term[$high(r_term)], r_term} + w_min_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_LEVEL]) begin
            priority if (w_val > w_max_x) begin
                r_level <= i_cfg.peak_max;
            end else if (w_val < w_min_x) begin
                r_level <= i_cfg.peak_min;
            end else begin
                r_level <= w_val[LVL_W-1:0];
            end
        end
    end

    assign o_level = r_level;

    // Lowest and highest level the clamp can give; a reversed range swaps the bounds
    assign w_lo_bound = (i_cfg.peak_max >= i_cfg.peak_min) ? i_cfg.peak_min : i_cfg.peak_max;
    assign w_hi_bound = (i_cfg.peak_max >= i_cfg.peak_min) ? i_cfg.peak_max : i_cfg.peak_min;

    `APHCM_ASSERT(a_level_bounded, $past(i_ctl.adv[ST_LEVEL]) |-> ((r_level >= $past(w_lo_bound)) && (r_level <= $past(w_hi_bound))), "level outside clamp bounds")

endmodule

### sv/aphcm_mix.sv
// Mix stage: scale each color channel by the level, divide by 255 with rounding.
// Depends on aphcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aphcm_mix
    import aphcm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic signed [LVL_W-1:0] i_level,
    input  t_rgb                    i_rgb,
    output logic signed [LVL_W-1:0] o_level,
    output logic signed [LVL_W-1:0] o_red,
    output logic signed [LVL_W-1:0] o_green,
    output logic signed [LVL_W-1:0] o_blue
);

    logic [LVL_W-1:0]                         w_abs;
    logic [2:0][MIX_Y_W-1:0]                  w_p;
    logic [2:0][MIX_Y_W-1:0]                  w_y;
    logic [2:0][MIX_Y_W-1:0]                  r_y;
    logic                                     r_neg;
    logic signed [LVL_W-1:0]                  r_lvl_mix;
    logic [2:0][MIX_Y_W+MIX_RECIP_W-1:0]      w_qp;
    logic [2:0][LVL_W-1:0]                    w_q;
    logic [2:0][LVL_W-1:0]                    r_out;
    logic signed [LVL_W-1:0]                  r_lvl_out;

    // Form 2*ch*|level| + 255 for each channel
    always_comb begin
        w_abs = i_level[LVL_W-1] ? LVL_W'(-i_level) : LVL_W'(i_level);
        for (int c = 0; c < 3; c++) begin
            w_p[c] = i_rgb[c] * w_abs;
            w_y[c] = {w_p[c][MIX_Y_W-2:0], 1'b0} + MIX_Y_W'(255);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_MIX]) begin
            r_y       <= w_y;
            r_neg     <= i_level[LVL_W-1];
            r_lvl_mix <= i_level;
        end
    end

    // Divide by 510 through the reciprocal, then restore the sign
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_qp[c] = r_y[c] * MIX_RECIP;
            w_q[c]  = w_qp[c][MIX_SHIFT +: LVL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_OUT]) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= r_neg ? LVL_W'(-w_q[c]) : w_q[c];
            end
            r_lvl_out <= r_lvl_mix;
        end
    end

    assign o_level = r_lvl_out;
    assign o_red   = r_out[CH_RED];
    assign o_green = r_out[CH_GREEN];
    assign o_blue  = r_out[CH_BLUE];

    `APHCM_ASSERT(a_zero_level_dark, (i_ctl.vld[ST_OUT] && (r_lvl_out == '0)) |-> (r_out == '0), "color nonzero at zero level")

endmodule

### sv/audio_peak_hue_color_mapper.sv
// Audio peak hue color mapper, top level.
// Depends on aphcm_pkg, aphcm_ctrl, aphcm_hue, aphcm_level and aphcm_mix.
//
// Each input beat carries a peak level and a hue angle and yields one output beat
// with the clamped level and the three color channels scaled by it. The block is a
// seven-stage pipeline whose rate, one beat per cycle, is set by the pipeline and
// held back only by m_axis_tready; a result is offered at the output once its beat
// has passed the gain, gain, scale, round, level, mix and output registers. Each
// stage is at most one multiply deep (gain, gain, range scale, channel times level,
// then the divide-by-510 reciprocal). Ready ripples back through the stages, so
// empty stages are filled even while a result waits at the output. Hue rotation
// uses a 90-row constant table holding all four quadrants. Configuration registers
// are written through the plain write port and must be changed only while no beat
// is in flight; there is no read-back and no clearing pass after reset.
module audio_peak_hue_color_mapper
    import aphcm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] peak_level, [24:16] hue_degrees
    // Output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] level, [31:16] red_out,
                                                   // [47:32] green_out, [63:48] blue_out
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg                    r_cfg;
    t_pipe_ctl               w_ctl;
    t_rgb                    w_rgb;
    logic signed [LVL_W-1:0] w_level_pipe;
    logic signed [LVL_W-1:0] w_level;
    logic signed [LVL_W-1:0] w_red;
    logic signed [LVL_W-1:0] w_green;
    logic signed [LVL_W-1:0] w_blue;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_PEAK_MIN:      r_cfg.peak_min      <= i_cfg_wdata;
                CFG_PEAK_MAX:      r_cfg.peak_max      <= i_cfg_wdata;
                CFG_MATERIAL_GAIN: r_cfg.material_gain <= i_cfg_wdata;
                CFG_GLOBAL_GAIN:   r_cfg.global_gain   <= i_cfg_wdata;
                CFG_COLOR_MODE:    r_cfg.color_mode    <= t_color_mode'(i_cfg_wdata[2:0]);
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    aphcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl)
    );

    aphcm_hue u_hue (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_cfg         (r_cfg),
        .i_hue_degrees (s_axis_tdata[PEAK_W +: HUE_W]),
        .o_rgb         (w_rgb)
    );

    aphcm_level u_level (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_cfg        (r_cfg),
        .i_peak_level (s_axis_tdata[PEAK_W-1:0]),
        .o_level      (w_level_pipe)
    );

    aphcm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_level (w_level_pipe),
        .i_rgb   (w_rgb),
        .o_level (w_level),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    // Pack the result beat, first field lowest
    assign m_axis_tdata = {w_blue, w_green, w_red, w_level};

endmodule
